>>> hdl/ltn_pkg.sv
`timescale 1ns / 1ps
package ltn_pkg;

  // Subtag buffer depth
  localparam int SUB_MAX = 8;

  // Separators and the private-use singleton
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_X     = 8'h78;

  // Status codes of the final item
  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_EMPTY         = 4'd1;
  localparam logic [3:0] ST_TOO_LONG      = 4'd2;
  localparam logic [3:0] ST_BAD_CHAR      = 4'd3;
  localparam logic [3:0] ST_EMPTY_SUBTAG  = 4'd4;
  localparam logic [3:0] ST_SUBTAG_LONG   = 4'd5;
  localparam logic [3:0] ST_BARE_PRIVATE  = 4'd6;
  localparam logic [3:0] ST_BAD_LANGUAGE  = 4'd7;
  localparam logic [3:0] ST_NO_VALUE      = 4'd8;
  localparam logic [3:0] ST_DUP_SINGLETON = 4'd9;
  localparam logic [3:0] ST_ORDER         = 4'd11;
  localparam logic [3:0] ST_DUP_VARIANT   = 4'd12;
  localparam logic [3:0] ST_VARIANT_FULL  = 4'd13;

  typedef enum logic [1:0] {
    MODE_LOWER,
    MODE_TITLE,
    MODE_UPPER
  } case_mode_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       no_byte;
    logic       end_of_tag;
  } item_t;

  typedef struct packed {
    logic [7:0] char_value;
    logic       has_char;
    logic       is_last;
    logic [3:0] status;
    logic [7:0] error_offset;
  } result_t;

  // One classified subtag (and/or the end status) handed to the back part
  typedef struct packed {
    logic [SUB_MAX-1:0][7:0] chars;
    logic [3:0]              len;
    case_mode_t              mode;
    logic                    emit;
    logic                    dash;
    logic                    last;
    logic [3:0]              status;
    logic [7:0]              offset;
  } job_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

endpackage

>>> hdl/ltn_front.sv
`timescale 1ns / 1ps
module ltn_front #(
  parameter int MAX_TAG_BYTES = 255,
  parameter int VARIANT_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  ltn_pkg::item_t   item,
  output logic             job_push,
  output ltn_pkg::job_t    job
);
  import ltn_pkg::*;

  localparam int TLW = $clog2(MAX_TAG_BYTES + 2);
  localparam int VCW = $clog2(VARIANT_SLOTS + 1);
  localparam int VIW = (VARIANT_SLOTS > 1) ? $clog2(VARIANT_SLOTS) : 1;
  localparam logic [TLW-1:0] MAX_TL = TLW'(MAX_TAG_BYTES);

  // Parse flag bits
  localparam int FL_SCRIPT  = 0;
  localparam int FL_REGION  = 1;
  localparam int FL_VARIANT = 2;
  localparam int FL_EXT     = 3;
  localparam int FL_PRIV    = 4;
  localparam int FL_NEED    = 5;
  localparam int FL_PFRONT  = 6;

  // Tag state
  logic [7:0]     sub_buf [SUB_MAX];
  logic [3:0]     sub_len;
  logic [TLW-1:0] tag_len;
  logic [7:0]     sub_start;
  logic [7:0]     ordinal;
  logic [6:0]     flags;
  logic [1:0]     ext_cnt;
  logic [35:0]    smask;
  logic [63:0]    vstore [VARIANT_SLOTS];
  logic [VCW-1:0] vcount;
  logic           lex_v;
  logic [3:0]     lex_code;
  logic [7:0]     lex_off;
  logic [3:0]     struct_err;

  // Working values
  logic           has_byte, is_sep, in_range;
  logic [7:0]     idx8, close_off;
  logic [TLW-1:0] tag_len_a;
  logic [7:0]     sbuf_a [SUB_MAX];
  logic [3:0]     len_a;
  logic           lexv_a, lexv_c;
  logic [3:0]     lexc_a, lexc_c;
  logic [7:0]     lexo_a, lexo_c;
  logic           sep_close, end_close, do_close, cls_en;
  logic           letters_only, all_digit, vmatch, vwr;
  logic [63:0]    key;
  logic [7:0]     b0, lb0;
  logic [5:0]     sidx;
  case_mode_t     mode;
  logic [6:0]     flags_c;
  logic [1:0]     ext_c;
  logic [35:0]    smask_c;
  logic [VCW-1:0] vcount_c;
  logic [3:0]     struct_c;
  logic [7:0]     ordinal_c;
  logic           emit;
  logic [3:0]     st;
  logic [7:0]     st_off;

  // Append, close and classify for one item
  always_comb begin
    has_byte  = !item.no_byte;
    is_sep    = item.byte_value == CH_DASH || item.byte_value == CH_UNDER;
    in_range  = has_byte && (tag_len < MAX_TL);
    idx8      = 8'(tag_len);
    tag_len_a = tag_len;
    if (has_byte) begin
      tag_len_a = in_range ? tag_len + TLW'(1) : MAX_TL + TLW'(1);
    end

    // byte append with the bad-character check
    sbuf_a = sub_buf;
    len_a  = sub_len;
    lexv_a = lex_v;
    lexc_a = lex_code;
    lexo_a = lex_off;
    if (in_range && !is_sep) begin
      if (!lex_v && !is_alpha(item.byte_value) && !is_digit(item.byte_value)) begin
        lexv_a = 1'b1;
        lexc_a = ST_BAD_CHAR;
        lexo_a = idx8;
      end
      if (sub_len < 4'd8) sbuf_a[sub_len[2:0]] = item.byte_value;
      if (sub_len <= 4'd8) len_a = sub_len + 4'd1;
    end

    // subtag close and its length checks
    sep_close = in_range && is_sep;
    end_close = item.end_of_tag && !sep_close && tag_len_a != '0 && tag_len_a <= MAX_TL;
    do_close  = sep_close || end_close;
    close_off = sep_close ? idx8 : 8'(tag_len_a);
    lexv_c = lexv_a;
    lexc_c = lexc_a;
    lexo_c = lexo_a;
    if (do_close && !lexv_a) begin
      if (len_a == 4'd0) begin
        lexv_c = 1'b1;
        lexc_c = ST_EMPTY_SUBTAG;
        lexo_c = close_off;
      end else if (len_a > 4'd8) begin
        lexv_c = 1'b1;
        lexc_c = ST_SUBTAG_LONG;
        lexo_c = sub_start;
      end
    end
    cls_en = do_close && !lexv_c && struct_err == 4'd0;

    // subtag shape and variant key
    letters_only = 1'b1;
    all_digit    = 1'b1;
    for (int i = 0; i < SUB_MAX; i++) begin
      if (4'(i) < len_a) begin
        if (!is_alpha(sbuf_a[i])) letters_only = 1'b0;
        if (!is_digit(sbuf_a[i])) all_digit = 1'b0;
        key[8*i +: 8] = to_lower(sbuf_a[i]);
      end else begin
        key[8*i +: 8] = 8'h00;
      end
    end
    vmatch = 1'b0;
    for (int j = 0; j < VARIANT_SLOTS; j++) begin
      if (VCW'(j) < vcount && vstore[j] == key) vmatch = 1'b1;
    end
    b0   = sbuf_a[0];
    lb0  = to_lower(b0);
    sidx = is_digit(b0) ? 6'(b0 - 8'd48) : 6'(lb0 - 8'd87);

    // classification
    mode     = MODE_LOWER;
    flags_c  = flags;
    ext_c    = ext_cnt;
    smask_c  = smask;
    vcount_c = vcount;
    struct_c = struct_err;
    vwr      = 1'b0;
    if (cls_en) begin
      if (ordinal == 8'd0) begin
        if (len_a == 4'd1 && lb0 == CH_X) begin
          flags_c[FL_PFRONT] = 1'b1;
          flags_c[FL_PRIV]   = 1'b1;
        end else if (!(len_a >= 4'd2 && letters_only)) begin
          struct_c = ST_BAD_LANGUAGE;
        end
      end else if (flags[FL_PFRONT]) begin
        mode = MODE_LOWER;
      end else if (len_a == 4'd1) begin
        if (flags[FL_PRIV]) begin
          flags_c[FL_NEED] = 1'b0;
        end else if (flags[FL_NEED]) begin
          struct_c = ST_NO_VALUE;
        end else if (smask[sidx]) begin
          struct_c = ST_DUP_SINGLETON;
        end else begin
          smask_c[sidx] = 1'b1;
          if (lb0 == CH_X) begin
            flags_c[FL_PRIV] = 1'b1;
            flags_c[FL_EXT]  = 1'b0;
          end else begin
            flags_c[FL_EXT] = 1'b1;
          end
          flags_c[FL_NEED] = 1'b1;
        end
      end else if (flags[FL_EXT] || flags[FL_PRIV]) begin
        flags_c[FL_NEED] = 1'b0;
      end else if (len_a == 4'd3 && letters_only && ext_cnt < 2'd3 &&
                   !(flags[FL_SCRIPT] || flags[FL_REGION] || flags[FL_VARIANT])) begin
        ext_c = ext_cnt + 2'd1;
      end else if (len_a == 4'd4 && letters_only &&
                   !(flags[FL_SCRIPT] || flags[FL_REGION] || flags[FL_VARIANT])) begin
        flags_c[FL_SCRIPT] = 1'b1;
        mode = MODE_TITLE;
      end else if (len_a == 4'd2 && letters_only &&
                   !(flags[FL_REGION] || flags[FL_VARIANT])) begin
        flags_c[FL_REGION] = 1'b1;
        mode = MODE_UPPER;
      end else if (len_a == 4'd3 && all_digit && !(flags[FL_REGION] || flags[FL_VARIANT])) begin
        flags_c[FL_REGION] = 1'b1;
      end else if (len_a >= 4'd5 || (len_a == 4'd4 && is_digit(b0))) begin
        if (vmatch) begin
          struct_c = ST_DUP_VARIANT;
        end else if (vcount >= VCW'(VARIANT_SLOTS)) begin
          struct_c = ST_VARIANT_FULL;
        end else begin
          vwr = 1'b1;
          vcount_c = vcount + VCW'(1);
          flags_c[FL_VARIANT] = 1'b1;
        end
      end else begin
        struct_c = ST_ORDER;
      end
    end
    ordinal_c = (do_close && ordinal != 8'd255) ? ordinal + 8'd1 : ordinal;

    // end-of-tag status
    st     = ST_OK;
    st_off = 8'd0;
    if (tag_len_a == '0) begin
      st = ST_EMPTY;
    end else if (tag_len_a > MAX_TL) begin
      st = ST_TOO_LONG;
    end else if (lexv_c) begin
      st     = lexc_c;
      st_off = lexo_c;
    end else if (sep_close) begin
      st     = ST_EMPTY_SUBTAG;
      st_off = 8'(tag_len_a);
    end else if (struct_c != 4'd0) begin
      st = struct_c;
    end else if (flags_c[FL_PFRONT] && ordinal_c == 8'd1) begin
      st = ST_BARE_PRIVATE;
    end else if (flags_c[FL_NEED]) begin
      st = ST_NO_VALUE;
    end

    // job for the back part
    emit = do_close && !lexv_c && !(sep_close && item.end_of_tag);
    for (int k = 0; k < SUB_MAX; k++) job.chars[k] = sbuf_a[k];
    job.len    = len_a;
    job.mode   = mode;
    job.emit   = emit;
    job.dash   = emit && sep_close;
    job.last   = item.end_of_tag;
    job.status = item.end_of_tag ? st : ST_OK;
    job.offset = item.end_of_tag ? st_off : 8'd0;
    job_push   = accept && (item.end_of_tag || emit);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst || (accept && item.end_of_tag)) begin
      sub_len    <= 4'd0;
      tag_len    <= '0;
      sub_start  <= 8'd0;
      ordinal    <= 8'd0;
      flags      <= '0;
      ext_cnt    <= 2'd0;
      smask      <= '0;
      vcount     <= '0;
      lex_v      <= 1'b0;
      lex_code   <= 4'd0;
      lex_off    <= 8'd0;
      struct_err <= 4'd0;
    end else if (accept) begin
      sub_len    <= do_close ? 4'd0 : len_a;
      tag_len    <= tag_len_a;
      sub_start  <= do_close ? close_off + 8'd1 : sub_start;
      ordinal    <= ordinal_c;
      flags      <= flags_c;
      ext_cnt    <= ext_c;
      smask      <= smask_c;
      vcount     <= vcount_c;
      lex_v      <= lexv_c;
      lex_code   <= lexc_c;
      lex_off    <= lexo_c;
      struct_err <= struct_c;
    end
  end

  // Subtag buffer and variant store
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < SUB_MAX; k++) sub_buf[k] <= sbuf_a[k];
      if (vwr) vstore[vcount[VIW-1:0]] <= key;
    end
  end

endmodule

>>> hdl/ltn_jobq.sv
`timescale 1ns / 1ps
module ltn_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  ltn_pkg::job_t wdata,
  output logic          full,
  input  logic          rd,
  output ltn_pkg::job_t rdata,
  output logic          valid
);
  import ltn_pkg::*;

  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign valid = cnt != 2'd0;
  assign rdata = mem[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

endmodule

>>> hdl/ltn_back.sv
`timescale 1ns / 1ps
module ltn_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  ltn_pkg::job_t    job,
  output logic             job_pop,
  input  logic             taken,
  output logic             out_valid,
  output ltn_pkg::result_t result
);
  import ltn_pkg::*;

  logic [3:0] pos, nchar, total;
  logic [7:0] c;
  logic       load;
  result_t    res;

  // Sequence the characters, dash and status of the head job
  always_comb begin
    nchar = job.emit ? job.len : 4'd0;
    total = nchar + 4'(job.dash) + 4'(job.last);
    c     = job.chars[pos[2:0]];
    res   = '0;
    if (pos < nchar) begin
      res.has_char = 1'b1;
      if (job.mode == MODE_UPPER || (job.mode == MODE_TITLE && pos == 4'd0)) begin
        res.char_value = to_upper(c);
      end else begin
        res.char_value = to_lower(c);
      end
    end else if (pos == nchar && job.dash) begin
      res.has_char   = 1'b1;
      res.char_value = CH_DASH;
    end else begin
      res.is_last      = 1'b1;
      res.status       = job.status;
      res.error_offset = job.offset;
    end
    load    = job_valid && (!out_valid || taken);
    job_pop = load && (pos + 4'd1 == total);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 4'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= job_pop ? 4'd0 : pos + 4'd1;
    end else if (taken) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= res;
  end

endmodule

>>> hdl/language_tag_normalizer.sv
`timescale 1ns / 1ps
// Language tag case normalizer. Bytes of a tag go in one per transfer; each subtag is checked
// and classified when its separator (or the tag end) arrives and comes out in canonical case,
// one character per result, followed by '-' if a separator closed it, and every tag ends with
// one status result. The input side takes one byte per clock while its two-entry job queue has
// room; the output side delivers one result per clock while results are popped, each character
// and dash of a subtag and the tag end taking a result of its own. The back part's single
// output register sets the sustained rate.
module language_tag_normalizer #(
  parameter int MAX_TAG_BYTES = 255,
  parameter int VARIANT_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  ltn_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output ltn_pkg::result_t result
);
  import ltn_pkg::*;

  logic job_push, job_pop, job_valid, out_valid, accept;
  job_t job_in, job_out;

  assign accept = push && !full;
  assign empty  = !out_valid;

  // Front: buffering and classification
  ltn_front #(
    .MAX_TAG_BYTES(MAX_TAG_BYTES),
    .VARIANT_SLOTS(VARIANT_SLOTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .job_push(job_push),
    .job     (job_in)
  );

  // Job queue between the two parts
  ltn_jobq u_jobq (
    .clk  (clk),
    .rst  (rst),
    .wr   (job_push),
    .wdata(job_in),
    .full (full),
    .rd   (job_pop),
    .rdata(job_out),
    .valid(job_valid)
  );

  // Back: result emission
  ltn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job_out),
    .job_pop  (job_pop),
    .taken    (pop && out_valid),
    .out_valid(out_valid),
    .result   (result)
  );

endmodule

>>> hdl/ltn_checker.sv
`timescale 1ns / 1ps
module ltn_checker (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input ltn_pkg::result_t result
);
  import ltn_pkg::*;

  // Nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // A waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("result changed while stalled");

  // Status results carry no character
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    !empty && result.is_last |-> !result.has_char && result.char_value == 8'd0)
    else $error("status result carries a character");

  // Character results carry no status
  a_char_shape: assert property (@(posedge clk) disable iff (rst)
    !empty && result.has_char |-> !result.is_last && result.status == ST_OK &&
    result.error_offset == 8'd0)
    else $error("character result carries status");

  // Offset only with lexical errors
  a_offset: assert property (@(posedge clk) disable iff (rst)
    !empty && result.is_last && result.status != ST_BAD_CHAR &&
    result.status != ST_EMPTY_SUBTAG && result.status != ST_SUBTAG_LONG
    |-> result.error_offset == 8'd0)
    else $error("offset without lexical error");

endmodule

bind language_tag_normalizer ltn_checker u_ltn_checker (.*);
